[src/slrng_pkg.sv]
// shared types and constants of the subtractive lagged rng
package slrng_pkg;

	// table entries stay below the modulus, so 30 bits hold them
	typedef logic [29:0] word_t;
	typedef logic [5:0]  addr_t;

	// one write port group into the lag table
	typedef struct packed {
		logic  en;
		addr_t addr;
		word_t data;
	} mem_wr_t;

	localparam word_t       MODULUS         = 30'd1000000000;
	localparam logic [31:0] MODULUS_W       = 32'd1000000000;
	localparam logic [32:0] START_OFFSET    = 33'd161803398;
	localparam addr_t       TABLE_LEN       = 6'd55;
	localparam logic [6:0]  TABLE_LEN_W     = 7'd55;
	localparam logic [6:0]  FILL_STRIDE     = 7'd21;
	localparam logic [6:0]  SCRAMBLE_LAG    = 7'd30;
	localparam logic [1:0]  LAST_PASS       = 2'd3;
	localparam addr_t       LAG_START       = 6'd31;
	localparam addr_t       FILL_LAST       = 6'd54;

endpackage

[src/slrng_mem.sv]
// 55-entry lag table, one write port and two registered read ports
module slrng_mem
	import slrng_pkg::*;
(
	input  logic    clk,
	input  mem_wr_t wr,
	input  addr_t   raddr_a,
	input  addr_t   raddr_b,
	output word_t   rdata_a,
	output word_t   rdata_b
);

	word_t mem_q [55];

	// write and registered reads
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

[src/slrng_submod.sv]
// shared modular subtractor: (a - b) mod 10^9 for a, b below 10^9
module slrng_submod
	import slrng_pkg::*;
(
	input  word_t a,
	input  word_t b,
	output word_t res
);

	logic [30:0] diff;

	// subtract, add the modulus back on borrow
	always_comb begin
		diff = {1'b0, a} - {1'b0, b};
		if (diff[30]) begin
			res = diff[29:0] + MODULUS;
		end else begin
			res = diff[29:0];
		end
	end

endmodule

[src/subtractive_lagged_rng_top.sv]
// Draw without reseed: draw read, draw write and output states lead to a registered
// result; no item is taken until the block is idle again. Reseed (negative seed or first
// item after reset) adds one start step, 54 fill steps and 220 scramble steps through
// the shared subtractor and the two-read table. Reset clears the pointers to 0 and 31
// and the seeded flag; the table is not cleared, since the first item always reseeds.
module subtractive_lagged_rng_top
	import slrng_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] seed_word,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [29:0]        draw_value,
	output logic signed [31:0] seed_back
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,
		ST_FILL,
		ST_SCR_RD,
		ST_SCR_WR,
		ST_DRAW_RD,
		ST_DRAW_WR,
		ST_OUT
	} state_t;

	state_t             state_q;
	logic signed [31:0] seed_q;
	logic signed [31:0] back_q;
	logic               seeded_q;
	addr_t              rp_q;
	addr_t              lp_q;
	word_t              prev_q;
	word_t              cur_q;
	addr_t              cnt_q;
	logic [6:0]         slot_q;
	logic [1:0]         pass_q;
	word_t              draw_q;
	logic               out_valid_q;
	word_t              out_draw_q;
	logic signed [31:0] out_back_q;

	mem_wr_t    wr;
	addr_t      raddr_a;
	addr_t      raddr_b;
	word_t      rdata_a;
	word_t      rdata_b;
	word_t      unit_a;
	word_t      unit_b;
	word_t      unit_res;
	addr_t      rp_nx;
	addr_t      lp_nx;
	logic [6:0] lag_idx;
	logic [6:0] slot_nx;
	logic [31:0] mag;
	logic [32:0] start_diff;
	logic [31:0] start_abs;
	word_t      start_val;
	logic       in_take;
	logic       out_free;

	slrng_mem u_mem (
		.clk     (clk),
		.wr      (wr),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	slrng_submod u_sub (
		.a   (unit_a),
		.b   (unit_b),
		.res (unit_res)
	);

	// handshake
	assign in_stall   = (state_q != ST_IDLE);
	assign in_take    = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign out_valid  = out_valid_q;
	assign draw_value = out_draw_q;
	assign seed_back  = out_back_q;

	// start value: |161803398 - |seed|| reduced once below 10^9
	always_comb begin
		mag        = seed_q[31] ? (~seed_q + 32'd1) : seed_q;
		start_diff = START_OFFSET - {1'b0, mag};
		start_abs  = start_diff[32] ? (~start_diff[31:0] + 32'd1) : start_diff[31:0];
		if (start_abs >= MODULUS_W) begin
			start_abs = start_abs - MODULUS_W;
		end
		start_val  = start_abs[29:0];
	end

	// pointer advance, scramble partner and fill slot stride
	always_comb begin
		rp_nx   = (rp_q >= TABLE_LEN) ? 6'd1 : rp_q + 6'd1;
		lp_nx   = (lp_q >= TABLE_LEN) ? 6'd1 : lp_q + 6'd1;
		lag_idx = {1'b0, cnt_q} + SCRAMBLE_LAG;
		if (lag_idx >= TABLE_LEN_W) begin
			lag_idx = lag_idx - TABLE_LEN_W;
		end
		slot_nx = slot_q + FILL_STRIDE;
		if (slot_nx >= TABLE_LEN_W) begin
			slot_nx = slot_nx - TABLE_LEN_W;
		end
	end

	// operand select for the shared subtractor
	always_comb begin
		if (state_q == ST_FILL) begin
			unit_a = prev_q;
			unit_b = cur_q;
		end else begin
			unit_a = rdata_a;
			unit_b = rdata_b;
		end
	end

	// table read addresses and write port
	always_comb begin
		raddr_a = cnt_q - 6'd1;
		raddr_b = lag_idx[5:0];
		wr.en   = 1'b0;
		wr.addr = cnt_q - 6'd1;
		wr.data = unit_res;
		case (state_q)
			ST_SEED: begin
				wr.en   = 1'b1;
				wr.addr = TABLE_LEN - 6'd1;
				wr.data = start_val;
			end
			ST_FILL: begin
				wr.en   = 1'b1;
				wr.addr = slot_q[5:0] - 6'd1;
				wr.data = cur_q;
			end
			ST_SCR_WR: begin
				wr.en = 1'b1;
			end
			ST_DRAW_RD: begin
				raddr_a = rp_nx - 6'd1;
				raddr_b = lp_nx - 6'd1;
			end
			ST_DRAW_WR: begin
				wr.en   = 1'b1;
				wr.addr = rp_q - 6'd1;
			end
			default: begin
			end
		endcase
	end

	// sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seeded_q    <= 1'b0;
			rp_q        <= 6'd0;
			lp_q        <= LAG_START;
			out_valid_q <= 1'b0;
			cnt_q       <= 6'd1;
			pass_q      <= 2'd0;
		end else begin
			// result taken downstream, unless a new one is loaded below
			if (out_valid_q && !out_stall && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						seed_q <= seed_word;
						back_q <= seed_word;
						if (seed_word[31] || !seeded_q) begin
							state_q <= ST_SEED;
						end else begin
							state_q <= ST_DRAW_RD;
						end
					end
				end
				ST_SEED: begin
					prev_q  <= start_val;
					cur_q   <= 30'd1;
					cnt_q   <= 6'd1;
					slot_q  <= FILL_STRIDE;
					state_q <= ST_FILL;
				end
				ST_FILL: begin
					prev_q <= cur_q;
					cur_q  <= unit_res;
					if (cnt_q == FILL_LAST) begin
						cnt_q   <= 6'd1;
						pass_q  <= 2'd0;
						state_q <= ST_SCR_RD;
					end else begin
						cnt_q  <= cnt_q + 6'd1;
						slot_q <= slot_nx;
					end
				end
				ST_SCR_RD: begin
					state_q <= ST_SCR_WR;
				end
				ST_SCR_WR: begin
					if (cnt_q == TABLE_LEN) begin
						cnt_q <= 6'd1;
						if (pass_q == LAST_PASS) begin
							rp_q     <= 6'd0;
							lp_q     <= LAG_START;
							seeded_q <= 1'b1;
							back_q   <= 32'sd1;
							state_q  <= ST_DRAW_RD;
						end else begin
							pass_q  <= pass_q + 2'd1;
							state_q <= ST_SCR_RD;
						end
					end else begin
						cnt_q   <= cnt_q + 6'd1;
						state_q <= ST_SCR_RD;
					end
				end
				ST_DRAW_RD: begin
					rp_q    <= rp_nx;
					lp_q    <= lp_nx;
					state_q <= ST_DRAW_WR;
				end
				ST_DRAW_WR: begin
					draw_q  <= unit_res;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_draw_q  <= draw_q;
						out_back_q  <= back_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[bench/tb_subtractive_lagged_rng_top.sv]
// self-checking bench for the subtractive lagged rng: random seed stream, predictor, scoreboard
`timescale 1ns / 1ps

module tb_subtractive_lagged_rng_top;
	import slrng_pkg::*;

	localparam int RANDOM_ITEMS     = 1833;
	localparam int DRAIN_ITEM       = 900;
	localparam int TAIL_ITEMS       = 200;
	localparam int LONG_HOLD_AT     = 400;
	localparam int LONG_HOLD_CYCLES = 250;
	localparam int WATCHDOG_LIMIT   = 5000;
	localparam int SETTLE_CYCLES    = 20;
	localparam int SHOWN_MISMATCHES = 10;

	typedef struct {
		logic signed [31:0] seed;
		bit                 drain_first;
	} seed_item_t;

	typedef struct {
		word_t              draw;
		logic signed [31:0] back;
	} draw_expect_t;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               in_valid   = 1'b0;
	logic               in_stall;
	logic signed [31:0] seed_word  = '0;
	logic               out_valid;
	logic               out_stall  = 1'b0;
	logic [29:0]        draw_value;
	logic signed [31:0] seed_back;

	seed_item_t   pending_seeds [$];
	draw_expect_t expected_draws [$];

	// predictor state of the generator
	word_t lag_tab [1:55];
	int    rd_ptr     = 0;
	int    lag_ptr    = int'(LAG_START);
	bit    rng_seeded = 1'b0;

	int items_total     = 0;
	int items_sent      = 0;
	int results_seen    = 0;
	int mismatches      = 0;
	int send_gap        = 0;
	int stall_gap       = 0;
	int long_hold_left  = 0;
	bit long_hold_done  = 1'b0;
	int idle_cycles     = 0;

	subtractive_lagged_rng_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.seed_word  (seed_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.draw_value (draw_value),
		.seed_back  (seed_back)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// difference modulo 10^9 of two table words
	function automatic word_t mod_diff(input word_t a, input word_t b);
		longint d;
		d = longint'(a) - longint'(b);
		if (d < 0)
			d += longint'(MODULUS_W);
		return word_t'(d);
	endfunction

	// refill and scramble the lag table from a seed word
	task automatic reseed_table(input logic signed [31:0] s);
		longint mag;
		longint start;
		word_t  prev;
		word_t  cur;
		word_t  nxt;
		int     i;
		int     k;
		mag = (s < 0) ? -longint'(s) : longint'(s);
		start = longint'(START_OFFSET) - mag;
		if (start < 0)
			start = -start;
		start = start % longint'(MODULUS_W);
		prev = word_t'(start);
		lag_tab[int'(TABLE_LEN)] = prev;
		cur = word_t'(1);
		for (i = 1; i < int'(TABLE_LEN); i++) begin
			lag_tab[(int'(FILL_STRIDE) * i) % int'(TABLE_LEN)] = cur;
			nxt = mod_diff(prev, cur);
			prev = cur;
			cur = nxt;
		end
		for (k = 0; k <= int'(LAST_PASS); k++)
			for (i = 1; i <= int'(TABLE_LEN); i++)
				lag_tab[i] = mod_diff(lag_tab[i],
					lag_tab[1 + (i + int'(SCRAMBLE_LAG)) % int'(TABLE_LEN)]);
		rd_ptr = 0;
		lag_ptr = int'(LAG_START);
		rng_seeded = 1'b1;
	endtask

	// advance the generator by one accepted seed item and queue the expected draw
	task automatic predict_draw(input logic signed [31:0] s);
		draw_expect_t e;
		e.back = s;
		if (s < 0 || !rng_seeded) begin
			reseed_table(s);
			e.back = 32'sd1;
		end
		rd_ptr = (rd_ptr >= int'(TABLE_LEN)) ? 1 : rd_ptr + 1;
		lag_ptr = (lag_ptr >= int'(TABLE_LEN)) ? 1 : lag_ptr + 1;
		e.draw = mod_diff(lag_tab[rd_ptr], lag_tab[lag_ptr]);
		lag_tab[rd_ptr] = e.draw;
		expected_draws.push_back(e);
	endtask

	task automatic flag_mismatch(input string what, input longint want, input longint got);
		mismatches++;
		if (mismatches <= SHOWN_MISMATCHES)
			$display("mismatch on %s at result %0d: expected %0d, got %0d",
				what, results_seen, want, got);
	endtask

	// idling density by phase of the run, none near the end
	function automatic int idle_pct();
		if (pending_seeds.size() < TAIL_ITEMS)
			return 0;
		case ((items_sent / 150) % 3)
			0: begin
				return 0;
			end
			1: begin
				return 12;
			end
			default: begin
				return 35;
			end
		endcase
	endfunction

	// mostly plain draws, a few reseeds, half of them with seeds near the interesting start values
	function automatic logic signed [31:0] pick_seed();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3) begin
			case ($urandom_range(0, 3))
				0: begin
					return -(32'sd161803378 + $signed($urandom_range(0, 40)));
				end
				1: begin
					return -(32'sd1161803378 + $signed($urandom_range(0, 40)));
				end
				2: begin
					return ~$signed($urandom_range(0, 15));
				end
				default: begin
					return ~$signed($urandom() & 32'h7FFF_FFFF);
				end
			endcase
		end else if (r < 6) begin
			case ($urandom_range(0, 2))
				0: begin
					return 32'sd0;
				end
				1: begin
					return 32'sh7FFF_FFFF;
				end
				default: begin
					return $signed($urandom_range(0, 15));
				end
			endcase
		end
		return $signed($urandom() & 32'h7FFF_FFFF);
	endfunction

	// sender: offers seed items from the pending queue
	always @(posedge clk or negedge arst_n) begin : seed_driver
		seed_item_t nxt_item;
		logic       go;
		if (!arst_n) begin
			in_valid <= 1'b0;
			seed_word <= '0;
			send_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_draw(seed_word);
				items_sent++;
			end
			if (!(in_valid && in_stall)) begin
				go = 1'b0;
				if (send_gap == 0 && $urandom_range(0, 99) < idle_pct())
					send_gap = $urandom_range(1, 9);
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_seeds.size() > 0) begin
					if (!(pending_seeds[0].drain_first && expected_draws.size() > 0)) begin
						nxt_item = pending_seeds.pop_front();
						seed_word <= nxt_item.seed;
						go = 1'b1;
					end
				end
				in_valid <= go;
			end
		end
	end

	// receiver: long hold-off once, to fill the block and back up its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_hold_left <= 0;
			long_hold_done <= 1'b0;
		end else if (!long_hold_done && items_sent >= LONG_HOLD_AT) begin
			long_hold_left <= LONG_HOLD_CYCLES;
			long_hold_done <= 1'b1;
		end else if (long_hold_left > 0) begin
			long_hold_left <= long_hold_left - 1;
		end
	end

	// receiver: checks each draw against the oldest expectation
	always @(posedge clk or negedge arst_n) begin : draw_monitor
		draw_expect_t want;
		logic         hold;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_gap = 0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_draws.size() == 0) begin
					flag_mismatch("unexpected result draw_value", -1, draw_value);
				end else begin
					want = expected_draws.pop_front();
					if (draw_value !== want.draw)
						flag_mismatch("draw_value", want.draw, draw_value);
					if (seed_back !== want.back)
						flag_mismatch("seed_back", want.back, seed_back);
				end
			end
			if (stall_gap == 0 && $urandom_range(0, 99) < idle_pct())
				stall_gap = $urandom_range(1, 9);
			hold = (stall_gap > 0);
			if (hold)
				stall_gap--;
			out_stall <= hold || (long_hold_left > 0);
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// stimulus and end of run
	initial begin : run_ctrl
		int i;
		// directed: first item reseeds on a positive seed, then the seed extremes
		pending_seeds.push_back('{32'sd12345, 1'b0});
		pending_seeds.push_back('{32'sd0, 1'b0});
		pending_seeds.push_back('{32'sh7FFF_FFFF, 1'b0});
		pending_seeds.push_back('{32'sd1, 1'b0});
		pending_seeds.push_back('{-32'sd1, 1'b0});
		pending_seeds.push_back('{32'sd161803398, 1'b0});
		// start value exactly zero
		pending_seeds.push_back('{-32'sd161803398, 1'b0});
		pending_seeds.push_back('{32'sd5, 1'b0});
		pending_seeds.push_back('{-32'sd161803399, 1'b0});
		// large magnitude, start folds back through the modulus
		pending_seeds.push_back('{-32'sd1161803398, 1'b0});
		pending_seeds.push_back('{-32'sd1161803399, 1'b0});
		// most negative seed
		pending_seeds.push_back('{32'sh8000_0000, 1'b0});
		pending_seeds.push_back('{-32'sh7FFF_FFFF, 1'b0});
		pending_seeds.push_back('{32'sh5555_5555, 1'b0});
		pending_seeds.push_back('{32'sh2AAA_AAAA, 1'b0});
		pending_seeds.push_back('{32'shAAAA_AAAA, 1'b0});
		pending_seeds.push_back('{32'sd7, 1'b0});
		for (i = 0; i < RANDOM_ITEMS; i++)
			pending_seeds.push_back('{pick_seed(), (i == DRAIN_ITEM)});
		items_total = pending_seeds.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (items_sent < items_total || expected_draws.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_draws.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
